>>> sv/gci_pkg.sv
// ----------------------------------------------------------------------------
// gci_pkg
// Shared types, constants and the arctangent table function for the
// great circle intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gci_pkg;

    typedef logic signed [32:0] t_q30;   // signed Q2.30 with one guard bit
    typedef logic signed [63:0] t_w64;   // Q2.62 / Q60 cordic word
    typedef logic signed [65:0] t_prod;  // product of two t_q30

    localparam int          NUM_LANES       = 8;
    localparam logic [63:0] INV_GAIN_Q62    = 64'd2800459870029452954;
    localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9836E4E44152A;

    // atan(2^-i) in turns scaled to 2^64, evaluated at elaboration
    function automatic logic [63:0] atan_turn(input int i);
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [127:0] prod;
        int           e;
        sum = 64'd0;
        if (i == 0) begin
            return 64'h2000_0000_0000_0000;
        end
        for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 61) begin
                term = (64'd1 << (61 - e)) / 64'(2 * k + 1);
                if (k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        prod = {64'd0, sum << 1} * {64'd0, TWO_OVER_PI_Q64};
        return prod[127:64];
    endfunction

    // round half up from Q4.60 product down to Q2.30
    function automatic t_q30 rnd_q30(input logic signed [66:0] v);
        logic signed [66:0] t;
        t = (v + 67'sd536870912) >>> 30;
        return t[32:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/gci_sincos.sv
// ----------------------------------------------------------------------------
// gci_sincos
// Pipelined rotation cordic, one stage per iteration, for all eight input
// angles in parallel lanes; gives cosine and sine in Q2.30.
// ----------------------------------------------------------------------------
`default_nettype none

module gci_sincos import gci_pkg::*; #(
    parameter int CORDIC_STAGES = 30
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [63:0] i_angle [NUM_LANES],
    output logic             o_valid,
    output t_q30             o_cos   [NUM_LANES],
    output t_q30             o_sin   [NUM_LANES]
);

    logic        r_v [CORDIC_STAGES+1];
    t_w64        r_x [CORDIC_STAGES+1][NUM_LANES];
    t_w64        r_y [CORDIC_STAGES+1][NUM_LANES];
    t_w64        r_r [CORDIC_STAGES+1][NUM_LANES];
    logic [1:0]  r_q [CORDIC_STAGES+1][NUM_LANES];
    logic        r_ov;
    t_q30        r_c [NUM_LANES];
    t_q30        r_s [NUM_LANES];

    // quadrant reduction to [-pi/4, pi/4)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int l = 0; l < NUM_LANES; l++) begin
                logic [63:0] qs;
                qs = i_angle[l] + 64'h2000_0000_0000_0000;
                r_q[0][l] <= qs[63:62];
                r_r[0][l] <= i_angle[l] - {qs[63:62], 62'd0};
                r_x[0][l] <= INV_GAIN_Q62;
                r_y[0][l] <= 64'sd0;
            end
        end
    end

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
        localparam logic [63:0] ATAN = atan_turn(s);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
                for (int l = 0; l < NUM_LANES; l++) begin
                    r_q[s+1][l] <= r_q[s][l];
                    if (!r_r[s][l][63]) begin
                        r_x[s+1][l] <= r_x[s][l] - (r_y[s][l] >>> s);
                        r_y[s+1][l] <= r_y[s][l] + (r_x[s][l] >>> s);
                        r_r[s+1][l] <= r_r[s][l] - ATAN;
                    end else begin
                        r_x[s+1][l] <= r_x[s][l] + (r_y[s][l] >>> s);
                        r_y[s+1][l] <= r_y[s][l] - (r_x[s][l] >>> s);
                        r_r[s+1][l] <= r_r[s][l] + ATAN;
                    end
                end
            end
        end
    end

    // round to Q2.30 and undo the quadrant
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[CORDIC_STAGES];
            for (int l = 0; l < NUM_LANES; l++) begin
                t_w64 tc;
                t_w64 ts;
                t_q30 cq;
                t_q30 sq;
                tc = (r_x[CORDIC_STAGES][l] + 64'sd2147483648) >>> 32;
                ts = (r_y[CORDIC_STAGES][l] + 64'sd2147483648) >>> 32;
                cq = tc[32:0];
                sq = ts[32:0];
                unique case (r_q[CORDIC_STAGES][l])
                    2'd0: begin r_c[l] <= cq;  r_s[l] <= sq;  end
                    2'd1: begin r_c[l] <= -sq; r_s[l] <= cq;  end
                    2'd2: begin r_c[l] <= -cq; r_s[l] <= -sq; end
                    default: begin r_c[l] <= sq; r_s[l] <= -cq; end
                endcase
            end
        end
    end

    assign o_valid = r_ov;
    assign o_cos   = r_c;
    assign o_sin   = r_s;

endmodule

`default_nettype wire

>>> sv/gci_geom.sv
// ----------------------------------------------------------------------------
// gci_geom
// Unit vectors of the four points, the two circle normals, their cross
// product and the coincidence test, in eight register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gci_geom import gci_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  t_q30             i_cos [NUM_LANES],
    input  t_q30             i_sin [NUM_LANES],
    input  wire logic [61:0] i_min_sq,
    output logic             o_valid,
    output t_q30             o_a [3],
    output logic             o_degenerate
);

    logic        r_v [8];
    t_prod       r_pm [4][2];
    t_q30        r_pz [4];
    t_q30        r_p  [4][3];
    t_prod       r_nm [2][6];
    t_q30        r_n  [2][3];
    t_prod       r_am [6];
    t_q30        r_a  [3];
    t_q30        r_a2 [3];
    logic [63:0] r_sq [3];
    t_q30        r_a3 [3];
    logic        r_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < 8; k++) begin
                r_v[k] <= r_v[k-1];
            end
            // point vectors: (sin t cos p, sin t sin p, -cos t)
            for (int i = 0; i < 4; i++) begin
                r_pm[i][0] <= i_sin[2*i+1] * i_cos[2*i];
                r_pm[i][1] <= i_sin[2*i+1] * i_sin[2*i];
                r_pz[i]    <= -i_cos[2*i+1];
            end
            for (int i = 0; i < 4; i++) begin
                r_p[i][0] <= rnd_q30(67'(r_pm[i][0]));
                r_p[i][1] <= rnd_q30(67'(r_pm[i][1]));
                r_p[i][2] <= r_pz[i];
            end
            // circle normals
            for (int n = 0; n < 2; n++) begin
                r_nm[n][0] <= r_p[2*n][1] * r_p[2*n+1][2];
                r_nm[n][1] <= r_p[2*n][2] * r_p[2*n+1][1];
                r_nm[n][2] <= r_p[2*n][2] * r_p[2*n+1][0];
                r_nm[n][3] <= r_p[2*n][0] * r_p[2*n+1][2];
                r_nm[n][4] <= r_p[2*n][0] * r_p[2*n+1][1];
                r_nm[n][5] <= r_p[2*n][1] * r_p[2*n+1][0];
            end
            for (int n = 0; n < 2; n++) begin
                for (int c = 0; c < 3; c++) begin
                    r_n[n][c] <= rnd_q30(67'(r_nm[n][2*c]) - 67'(r_nm[n][2*c+1]));
                end
            end
            // intersection direction
            r_am[0] <= r_n[0][1] * r_n[1][2];
            r_am[1] <= r_n[0][2] * r_n[1][1];
            r_am[2] <= r_n[0][2] * r_n[1][0];
            r_am[3] <= r_n[0][0] * r_n[1][2];
            r_am[4] <= r_n[0][0] * r_n[1][1];
            r_am[5] <= r_n[0][1] * r_n[1][0];
            for (int c = 0; c < 3; c++) begin
                r_a[c] <= rnd_q30(67'(r_am[2*c]) - 67'(r_am[2*c+1]));
            end
            for (int c = 0; c < 3; c++) begin
                t_prod sq;
                sq = r_a[c] * r_a[c];
                r_sq[c] <= sq[63:0];
                r_a2[c] <= r_a[c];
            end
            r_deg <= (r_sq[0] + r_sq[1] + r_sq[2]) < {2'd0, i_min_sq};
            r_a3  <= r_a2;
        end
    end

    assign o_valid      = r_v[7];
    assign o_a          = r_a3;
    assign o_degenerate = r_deg;

endmodule

`default_nettype wire

>>> sv/gci_vec_cordic.sv
// ----------------------------------------------------------------------------
// gci_vec_cordic
// Pipelined vectoring cordic: angle of (x, y) in turns scaled to 2^64 and
// the gain-scaled magnitude, with a side word carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module gci_vec_cordic import gci_pkg::*; #(
    parameter int CORDIC_STAGES = 30,
    parameter int SIDE_W        = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  t_w64                   i_x,
    input  t_w64                   i_y,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [63:0]            o_angle,
    output t_w64                   o_mag,
    output logic [SIDE_W-1:0]      o_side
);

    logic              r_v [CORDIC_STAGES+1];
    t_w64              r_x [CORDIC_STAGES+1];
    t_w64              r_y [CORDIC_STAGES+1];
    logic [63:0]       r_z [CORDIC_STAGES+1];
    logic [SIDE_W-1:0] r_sd [CORDIC_STAGES+1];

    // fold the left half plane over, half a turn goes into the angle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0]  <= i_valid;
            r_sd[0] <= i_side;
            if (i_x[63]) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= 64'h8000_0000_0000_0000;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= 64'd0;
            end
        end
    end

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
        localparam logic [63:0] ATAN = atan_turn(s);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1]  <= r_v[s];
                r_sd[s+1] <= r_sd[s];
                if (r_y[s][63]) begin
                    r_x[s+1] <= r_x[s] - (r_y[s] >>> s);
                    r_y[s+1] <= r_y[s] + (r_x[s] >>> s);
                    r_z[s+1] <= r_z[s] - ATAN;
                end else begin
                    r_x[s+1] <= r_x[s] + (r_y[s] >>> s);
                    r_y[s+1] <= r_y[s] - (r_x[s] >>> s);
                    r_z[s+1] <= r_z[s] + ATAN;
                end
            end
        end
    end

    assign o_valid = r_v[CORDIC_STAGES];
    assign o_angle = r_z[CORDIC_STAGES];
    assign o_mag   = r_x[CORDIC_STAGES];
    assign o_side  = r_sd[CORDIC_STAGES];

endmodule

`default_nettype wire

>>> sv/gci_polar.sv
// ----------------------------------------------------------------------------
// gci_polar
// Spherical angles of the intersection vector: azimuth cordic, gain
// correction multiply, polar cordic, clamp and output rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module gci_polar import gci_pkg::*; #(
    parameter int ANGLE_BITS    = 32,
    parameter int CORDIC_STAGES = 30
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  t_q30             i_a [3],
    input  wire logic        i_degenerate,
    output logic             o_valid,
    output logic [31:0]      o_cross_phi,
    output logic [31:0]      o_cross_theta,
    output logic             o_degenerate
);

    localparam int          SH   = 64 - ANGLE_BITS;
    localparam logic [63:0] HALF = 64'd1 << (SH - 1);
    localparam int          S1_W = 1 + 33;
    localparam int          S2_W = 1 + 64;

    logic        v1_valid;
    logic [63:0] v1_angle;
    t_w64        v1_mag;
    logic [S1_W-1:0] v1_side;

    logic        v2_valid;
    logic [63:0] v2_angle;
    t_w64        v2_mag;
    logic [S2_W-1:0] v2_side;

    logic        r_pv;
    logic [63:0] r_pp [4];
    logic [63:0] r_phi1;
    t_q30        r_a2;
    logic        r_deg1;
    logic        r_rv;
    t_w64        r_rho;
    t_w64        r_x2;
    logic [63:0] r_phi2;
    logic        r_deg2;
    logic        r_ov;
    logic [31:0] r_phi_o;
    logic [31:0] r_theta_o;
    logic        r_deg_o;

    gci_vec_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES),
        .SIDE_W       (S1_W)
    ) u_vec_phi (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (i_en),
        .i_valid(i_valid),
        .i_x    (64'(i_a[0]) <<< 30),
        .i_y    (64'(i_a[1]) <<< 30),
        .i_side ({i_degenerate, i_a[2]}),
        .o_valid(v1_valid),
        .o_angle(v1_angle),
        .o_mag  (v1_mag),
        .o_side (v1_side)
    );

    // magnitude times inverse gain, high half of a 64 x 64 product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_rv <= 1'b0;
        end else if (i_en) begin
            logic [63:0]  mm;
            logic [127:0] full;
            mm = 64'(v1_mag) << 2;
            r_pv   <= v1_valid;
            r_pp[0] <= 64'(mm[31:0])  * 64'(INV_GAIN_Q62[31:0]);
            r_pp[1] <= 64'(mm[31:0])  * 64'(INV_GAIN_Q62[63:32]);
            r_pp[2] <= 64'(mm[63:32]) * 64'(INV_GAIN_Q62[31:0]);
            r_pp[3] <= 64'(mm[63:32]) * 64'(INV_GAIN_Q62[63:32]);
            r_phi1 <= v1_angle;
            r_a2   <= v1_side[32:0];
            r_deg1 <= v1_side[33];
            full = {r_pp[3], 64'd0} + {32'd0, r_pp[1], 32'd0}
                 + {32'd0, r_pp[2], 32'd0} + {64'd0, r_pp[0]};
            r_rv   <= r_pv;
            r_rho  <= full[127:64];
            r_x2   <= -(64'(r_a2) <<< 30);
            r_phi2 <= r_phi1;
            r_deg2 <= r_deg1;
        end
    end

    gci_vec_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES),
        .SIDE_W       (S2_W)
    ) u_vec_theta (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (i_en),
        .i_valid(r_rv),
        .i_x    (r_x2),
        .i_y    (r_rho),
        .i_side ({r_deg2, r_phi2}),
        .o_valid(v2_valid),
        .o_angle(v2_angle),
        .o_mag  (v2_mag),
        .o_side (v2_side)
    );

    // output register: clamp polar angle to [0, pi], round both angles, zero both when degenerate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            logic [63:0] th;
            logic [63:0] rp;
            logic [63:0] rt;
            priority if (v2_angle >= 64'hC000_0000_0000_0000) begin
                th = 64'd0;
            end else if (v2_angle > 64'h8000_0000_0000_0000) begin
                th = 64'h8000_0000_0000_0000;
            end else begin
                th = v2_angle;
            end
            rp = (v2_side[63:0] + HALF) >> SH;
            rt = (th + HALF) >> SH;
            r_ov <= v2_valid;
            r_deg_o <= v2_side[64];
            if (v2_side[64]) begin
                r_phi_o   <= 32'd0;
                r_theta_o <= 32'd0;
            end else begin
                r_phi_o   <= rp[31:0];
                r_theta_o <= rt[31:0];
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_cross_phi   = r_phi_o;
    assign o_cross_theta = r_theta_o;
    assign o_degenerate  = r_deg_o;

endmodule

`default_nettype wire

>>> sv/great_circle_intersection_unit.sv
// ----------------------------------------------------------------------------
// great_circle_intersection_unit
// Intersection direction of two great circles, each given by two sphere
// points, as azimuth and polar binary angles with a coincidence flag.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------------
//  points   | in        | i_valid / o_stall   | i_phi_*, i_theta_* (8 x 32 bit)
//  result   | out       | o_valid / i_stall   | o_cross_phi, o_cross_theta,
//           |           |                     | o_degenerate
//  config   | in        | i_cfg_valid/o_cfg_ready | i_cfg_min_norm (31 bit)
//
//  one transaction per cycle unless the result stalls; the data passes the
//  rotation cordic, the geometry multiplies and the two vectoring cordics
//  a stalled result freezes the whole pipeline, and o_stall follows it
//  synchronous active low reset clears valid bits and sets min_norm to 16
// ----------------------------------------------------------------------------
`default_nettype none

module great_circle_intersection_unit import gci_pkg::*; #(
    parameter int ANGLE_BITS    = 32,
    parameter int CORDIC_STAGES = 30
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_phi_first_a,
    input  wire logic [31:0] i_theta_first_a,
    input  wire logic [31:0] i_phi_first_b,
    input  wire logic [31:0] i_theta_first_b,
    input  wire logic [31:0] i_phi_second_a,
    input  wire logic [31:0] i_theta_second_a,
    input  wire logic [31:0] i_phi_second_b,
    input  wire logic [31:0] i_theta_second_b,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_cross_phi,
    output logic [31:0]      o_cross_theta,
    output logic             o_degenerate,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [30:0] i_cfg_min_norm
);

    localparam logic [63:0] ANGLE_MASK = (ANGLE_BITS >= 64) ? '1
                                       : ((64'd1 << ANGLE_BITS) - 64'd1);
    localparam int          IN_SH      = 64 - ANGLE_BITS;

    logic        en;
    logic [63:0] angles [NUM_LANES];
    logic        sc_valid;
    t_q30        sc_cos [NUM_LANES];
    t_q30        sc_sin [NUM_LANES];
    logic        gm_valid;
    t_q30        gm_a [3];
    logic        gm_deg;
    logic        pl_valid;

    logic [30:0] r_min_norm;
    logic [61:0] r_min_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_norm <= 31'd16;
            r_min_sq   <= 62'd256;
        end else begin
            if (i_cfg_valid) begin
                r_min_norm <= i_cfg_min_norm;
            end
            r_min_sq <= 62'(r_min_norm) * 62'(r_min_norm);
        end
    end

    assign o_cfg_ready = 1'b1;

    assign en      = !(pl_valid && i_stall);
    assign o_stall = pl_valid && i_stall;
    assign o_valid = pl_valid;

    assign angles[0] = (64'(i_phi_first_a)    & ANGLE_MASK) << IN_SH;
    assign angles[1] = (64'(i_theta_first_a)  & ANGLE_MASK) << IN_SH;
    assign angles[2] = (64'(i_phi_first_b)    & ANGLE_MASK) << IN_SH;
    assign angles[3] = (64'(i_theta_first_b)  & ANGLE_MASK) << IN_SH;
    assign angles[4] = (64'(i_phi_second_a)   & ANGLE_MASK) << IN_SH;
    assign angles[5] = (64'(i_theta_second_a) & ANGLE_MASK) << IN_SH;
    assign angles[6] = (64'(i_phi_second_b)   & ANGLE_MASK) << IN_SH;
    assign angles[7] = (64'(i_theta_second_b) & ANGLE_MASK) << IN_SH;

    gci_sincos #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_sincos (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(i_valid),
        .i_angle(angles),
        .o_valid(sc_valid),
        .o_cos  (sc_cos),
        .o_sin  (sc_sin)
    );

    gci_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (sc_valid),
        .i_cos       (sc_cos),
        .i_sin       (sc_sin),
        .i_min_sq    (r_min_sq),
        .o_valid     (gm_valid),
        .o_a         (gm_a),
        .o_degenerate(gm_deg)
    );

    gci_polar #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_polar (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (gm_valid),
        .i_a          (gm_a),
        .i_degenerate (gm_deg),
        .o_valid      (pl_valid),
        .o_cross_phi  (o_cross_phi),
        .o_cross_theta(o_cross_theta),
        .o_degenerate (o_degenerate)
    );

endmodule

`default_nettype wire

>>> bench/great_circle_intersection_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_intersection_unit_test
// Drives sphere point sets through the intersection pipeline with random
// gaps and back pressure, predicts every result bit for bit in the bench
// and checks each transaction in order, across several min_norm settings.
// ----------------------------------------------------------------------------
module great_circle_intersection_unit_test;
    import gci_pkg::*;

    localparam int STAGES      = 30;
    localparam int LATENCY     = 3 * STAGES + 14;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [63:0] GAIN_INV_Q62 = 64'd2800459870029452954;
    localparam logic [63:0] PI_HALF_INV  = 64'hA2F9836E4E44152A;
    localparam logic [30:0] NORM_AT_RESET = 31'd16;

    typedef logic signed [63:0] s64_t;

    typedef struct packed {
        logic [31:0] phi;
        logic [31:0] theta;
        logic        degenerate;
    } crossing_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_pt [8];
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_cross_phi;
    logic [31:0] o_cross_theta;
    logic        o_degenerate;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [30:0] i_cfg_min_norm = '0;

    s64_t        turn_table [STAGES];
    logic [30:0] norm_floor;
    crossing_t   crossings_due [$];
    int          errors = 0;
    int          cycles = 0;
    bit          no_gaps = 0;
    bit          hold_req = 0;
    int          hold_left = 0;
    int          stall_run = 0;

    initial for (int k = 0; k < 8; k++) i_pt[k] = '0;

    great_circle_intersection_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_phi_first_a(i_pt[0]), .i_theta_first_a(i_pt[1]),
        .i_phi_first_b(i_pt[2]), .i_theta_first_b(i_pt[3]),
        .i_phi_second_a(i_pt[4]), .i_theta_second_a(i_pt[5]),
        .i_phi_second_b(i_pt[6]), .i_theta_second_b(i_pt[7]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_cross_phi(o_cross_phi), .o_cross_theta(o_cross_theta),
        .o_degenerate(o_degenerate),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_min_norm(i_cfg_min_norm)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL great_circle_intersection_unit");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic logic [63:0] top_half(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[127:64];
    endfunction

    function automatic s64_t half_up(input s64_t v, input int s);
        s64_t t;
        t = v + (s64_t'(1) <<< (s - 1));
        return t >>> s;
    endfunction

    task automatic fill_turn_table();
        logic [63:0] acc;
        logic [63:0] term;
        int          k;
        turn_table[0] = s64_t'(64'h2000_0000_0000_0000);
        for (int i = 1; i < STAGES; i++) begin
            acc = 0;
            k = 0;
            while (i * (2 * k + 1) <= 61) begin
                term = (64'd1 << (61 - i * (2 * k + 1))) / 64'(2 * k + 1);
                if (k % 2 == 1) acc = acc - term;
                else acc = acc + term;
                k++;
            end
            turn_table[i] = s64_t'(top_half(acc << 1, PI_HALF_INV));
        end
    endtask

    task automatic rotate_unit(input logic [63:0] z, output s64_t c, output s64_t s);
        logic [63:0] q;
        logic [63:0] u;
        s64_t        r, x, y, dx, dy, cq, sq;
        q = ((z + (64'd1 << 61)) >> 62) & 64'd3;
        u = z - (q << 62) + (64'd1 << 61);
        r = s64_t'(u) - (s64_t'(1) <<< 61);
        x = s64_t'(GAIN_INV_Q62);
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0) begin
                x = x - dx; y = y + dy; r = r - turn_table[i];
            end else begin
                x = x + dx; y = y - dy; r = r + turn_table[i];
            end
        end
        cq = half_up(x, 32);
        sq = half_up(y, 32);
        case (q[1:0])
            2'd0: begin c = cq;  s = sq;  end
            2'd1: begin c = -sq; s = cq;  end
            2'd2: begin c = -cq; s = -sq; end
            default: begin c = sq; s = -cq; end
        endcase
    endtask

    task automatic heading_of(input s64_t x0, input s64_t y0,
                              output logic [63:0] ang, output s64_t mag);
        s64_t        x, y, z, dx, dy;
        logic [63:0] off;
        x = x0; y = y0; z = 0; off = 0;
        if (x < 0) begin
            x = -x; y = -y; off = 64'd1 << 63;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x = x - dx; y = y + dy; z = z - turn_table[i];
            end else begin
                x = x + dx; y = y - dy; z = z + turn_table[i];
            end
        end
        mag = x;
        ang = off + 64'(z);
    endtask

    task automatic to_vector(input logic [31:0] phi, input logic [31:0] theta,
                             output s64_t v0, output s64_t v1, output s64_t v2);
        s64_t ct, st, cp, sp;
        rotate_unit({theta, 32'd0}, ct, st);
        rotate_unit({phi, 32'd0}, cp, sp);
        v0 = half_up(st * cp, 30);
        v1 = half_up(st * sp, 30);
        v2 = -ct;
    endtask

    task automatic cross_of(input s64_t a [3], input s64_t b [3], output s64_t o [3]);
        o[0] = half_up(a[1] * b[2] - a[2] * b[1], 30);
        o[1] = half_up(a[2] * b[0] - a[0] * b[2], 30);
        o[2] = half_up(a[0] * b[1] - a[1] * b[0], 30);
    endtask

    function automatic logic [31:0] angle_out(input logic [63:0] a);
        logic [63:0] t;
        t = (a + (64'd1 << 31)) >> 32;
        return t[31:0];
    endfunction

    task automatic predict_crossing(input logic [31:0] pts [8], output crossing_t res);
        s64_t        p [4][3];
        s64_t        n1 [3], n2 [3], a [3];
        s64_t        m1, m2, rho;
        logic [63:0] sq_sum, mg, phi_a, theta_a;
        sq_sum = 0;
        for (int i = 0; i < 4; i++)
            to_vector(pts[2 * i], pts[2 * i + 1], p[i][0], p[i][1], p[i][2]);
        cross_of(p[0], p[1], n1);
        cross_of(p[2], p[3], n2);
        cross_of(n1, n2, a);
        for (int i = 0; i < 3; i++) begin
            mg = a[i] < 0 ? 64'(-a[i]) : 64'(a[i]);
            sq_sum = sq_sum + mg * mg;
        end
        if (sq_sum < 64'(norm_floor) * 64'(norm_floor)) begin
            res = '{phi: 32'd0, theta: 32'd0, degenerate: 1'b1};
        end else begin
            heading_of(a[0] <<< 30, a[1] <<< 30, phi_a, m1);
            rho = s64_t'(top_half(64'(m1) << 2, GAIN_INV_Q62));
            heading_of((-a[2]) <<< 30, rho, theta_a, m2);
            // cordic error past the poles is clamped
            if (theta_a >= (64'd3 << 62)) theta_a = 0;
            else if (theta_a > (64'd1 << 63)) theta_a = 64'd1 << 63;
            res = '{phi: angle_out(phi_a), theta: angle_out(theta_a), degenerate: 1'b0};
        end
    endtask

    // ---------------- result side ----------------
    always @(negedge i_clk) begin
        if (hold_left == 0 && hold_req) begin
            hold_left = 400;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (no_gaps) begin
            i_stall <= 1'b0;
        end else if (stall_run > 0) begin
            stall_run--;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < 10) begin
            stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                    : $urandom_range(0, 3);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        crossing_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (crossings_due.size() == 0) begin
                $display("%0t: unexpected transaction phi=%h theta=%h deg=%b",
                         $time, o_cross_phi, o_cross_theta, o_degenerate);
                errors++;
            end else begin
                want = crossings_due.pop_front();
                if (o_cross_phi !== want.phi) begin
                    $display("%0t: cross_phi expected %h actual %h",
                             $time, want.phi, o_cross_phi);
                    errors++;
                end
                if (o_cross_theta !== want.theta) begin
                    $display("%0t: cross_theta expected %h actual %h",
                             $time, want.theta, o_cross_theta);
                    errors++;
                end
                if (o_degenerate !== want.degenerate) begin
                    $display("%0t: degenerate expected %b actual %b",
                             $time, want.degenerate, o_degenerate);
                    errors++;
                end
            end
        end
    end

    // ---------------- point side ----------------
    task automatic send_points(input logic [31:0] pts [8]);
        crossing_t res;
        int        gap;
        @(negedge i_clk);
        for (int k = 0; k < 8; k++) i_pt[k] <= pts[k];
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        predict_crossing(pts, res);
        crossings_due.push_back(res);
        gap = 0;
        if (!no_gaps) begin
            case ($urandom_range(0, 19))
                0:       gap = $urandom_range(10, 40);
                1, 2, 3: gap = $urandom_range(1, 3);
                4, 5:    gap = 1;
                default: gap = 0;
            endcase
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (crossings_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 6) @(posedge i_clk);
    endtask

    task automatic write_min_norm(input logic [30:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_min_norm <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        norm_floor = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] polar_rand();
        case ($urandom_range(0, 19))
            0:       return $urandom();              // past pi, used as is
            1:       return 32'h8000_0000;
            2:       return 32'd0;
            default: return $urandom_range(32'h8000_0000, 0);
        endcase
    endfunction

    task automatic random_points(output logic [31:0] pts [8]);
        for (int k = 0; k < 8; k++)
            pts[k] = (k % 2 == 0) ? $urandom() : polar_rand();
        case ($urandom_range(0, 9))
            0: begin                                  // same circle twice
                pts[4] = pts[0]; pts[5] = pts[1]; pts[6] = pts[2]; pts[7] = pts[3];
            end
            1: begin                                  // one circle from a doubled point
                pts[2] = pts[0]; pts[3] = pts[1];
            end
            2: begin                                  // nearly coincident circles
                pts[4] = pts[0] + $urandom_range(0, 4000);
                pts[5] = pts[1]; pts[6] = pts[2];
                pts[7] = pts[3] - $urandom_range(0, 4000);
            end
            3: begin                                  // antipodal pair
                pts[2] = pts[0] + 32'h8000_0000;
                pts[3] = 32'h8000_0000 - pts[1];
            end
            default: ;
        endcase
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        logic [31:0] pts [8];
        logic [31:0] edges [6];
        edges = '{32'd0, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000, 32'hFFFF_FFFF, 32'd1};
        // equator and meridian circles
        pts = '{32'd0, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
                32'd0, 32'd0, 32'd0, 32'h4000_0000};
        send_points(pts);
        // identical circles
        pts = '{32'h1234_5678, 32'h2000_0000, 32'h9000_0000, 32'h6000_0000,
                32'h1234_5678, 32'h2000_0000, 32'h9000_0000, 32'h6000_0000};
        send_points(pts);
        // poles and polar angles past pi
        pts = '{32'h7000_0000, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000,
                32'h3000_0000, 32'hFFFF_FFFF, 32'hA000_0000, 32'hC000_0000};
        send_points(pts);
        // all fields at their extremes
        pts = '{default: 32'hFFFF_FFFF};
        send_points(pts);
        pts = '{default: 32'd0};
        send_points(pts);
        for (int n = 0; n < 14; n++) begin
            for (int k = 0; k < 8; k++) pts[k] = edges[$urandom_range(0, 5)];
            send_points(pts);
        end
        // circle points near the azimuth wrap, and an intersection near a pole
        pts = '{32'd0, 32'h4000_0000, 32'hFFFF_FFF0, 32'h4000_0000,
                32'h4000_0000, 32'h1000_0000, 32'hC000_0000, 32'h1000_0000};
        send_points(pts);
        pts = '{32'h4000_0000, 32'h7000_0000, 32'hC000_0000, 32'h7000_0000,
                32'd0, 32'h7000_0000, 32'h8000_0000, 32'h7000_0000};
        send_points(pts);
        drain();
    endtask

    task automatic test_random(input int count);
        logic [31:0] pts [8];
        for (int n = 0; n < count; n++) begin
            random_points(pts);
            send_points(pts);
        end
        drain();
    endtask

    task automatic test_back_to_back(input int count);
        logic [31:0] pts [8];
        no_gaps = 1;
        for (int n = 0; n < count; n++) begin
            random_points(pts);
            send_points(pts);
        end
        no_gaps = 0;
        drain();
    endtask

    task automatic test_long_hold();
        logic [31:0] pts [8];
        no_gaps = 1;
        hold_req = 1;
        for (int n = 0; n < 200; n++) begin
            random_points(pts);
            send_points(pts);
        end
        no_gaps = 0;
        drain();
    endtask

    initial begin
        fill_turn_table();
        norm_floor = NORM_AT_RESET;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(150);
        write_min_norm(31'd0);
        test_random(120);
        write_min_norm(31'h4000_0000);
        test_random(20);
        write_min_norm(31'h7FFF_FFFF);
        test_random(10);
        write_min_norm(31'($urandom_range(1000, 3000000)));
        test_back_to_back(80);
        write_min_norm(31'd1);
        test_long_hold();
        write_min_norm(31'h0015_5555);
        test_random(150);

        if (errors == 0) begin
            $display("PASS great_circle_intersection_unit");
        end else begin
            $display("FAIL great_circle_intersection_unit");
        end
        $finish;
    end

endmodule
